[src/vau_pkg.sv]
// shared types, codes and helpers for the vector arithmetic unit
`default_nettype none
package vau_pkg;

    localparam int DEF_IN_DEPTH  = 4;
    localparam int DEF_OUT_DEPTH = 4;
    localparam int ROOT_STEPS  = 32;
    localparam int DIV_STEPS   = 48;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic [3:0] FUNC_ADD   = 4'd0;
    localparam logic [3:0] FUNC_SUB   = 4'd1;
    localparam logic [3:0] FUNC_NEG   = 4'd2;
    localparam logic [3:0] FUNC_SCALE = 4'd3;
    localparam logic [3:0] FUNC_DIV   = 4'd4;
    localparam logic [3:0] FUNC_DOT   = 4'd5;
    localparam logic [3:0] FUNC_CROSS = 4'd6;
    localparam logic [3:0] FUNC_LENSQ = 4'd7;
    localparam logic [3:0] FUNC_LEN   = 4'd8;
    localparam logic [3:0] FUNC_NORM  = 4'd9;

    localparam logic signed [65:0] W_MAX = 66'sd2147483647;
    localparam logic signed [65:0] W_MIN = -66'sd2147483648;
    localparam logic signed [65:0] W_RND = 66'sd32768;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_DIV, OP_DOT, OP_CROSS,
        OP_LENSQ, OP_LEN, OP_NORM, OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROOT, ST_RND, ST_DIV, ST_FIN, ST_DONE
    } t_lu_state;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] s;
    } t_item;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] so;
        logic               err;
        logic               sat;
    } t_res;

    typedef struct packed {
        logic signed [31:0] v;
        logic               sat;
    } t_clamp;

    function automatic t_clamp sat32(input logic signed [65:0] v);
        t_clamp r;
        if (v > W_MAX) begin
            r.v   = 32'sh7FFF_FFFF;
            r.sat = 1'b1;
        end else if (v < W_MIN) begin
            r.v   = 32'sh8000_0000;
            r.sat = 1'b1;
        end else begin
            r.v   = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_long(input t_op op);
        return (op == OP_DIV) || (op == OP_LEN) || (op == OP_NORM);
    endfunction

endpackage
`default_nettype wire

[src/vau_queue.sv]
// small first-in first-out queue of packed words
`default_nettype none
module vau_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_rd,
    output logic      [WIDTH-1:0]           o_rdata,
    output logic                            o_full,
    output logic                            o_empty,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_rdata = r_mem[r_rp];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wp = (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
        end
        if (rd_en) begin
            n_rp = (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end
endmodule
`default_nettype wire

[src/vau_front.sv]
// front end: accepts transactions, decodes the operation and queues them
`default_nettype none
module vau_front #(
    parameter int IN_DEPTH = vau_pkg::DEF_IN_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire logic [3:0]          i_func,
    input  wire logic signed [31:0]  i_ax,
    input  wire logic signed [31:0]  i_ay,
    input  wire logic signed [31:0]  i_az,
    input  wire logic signed [31:0]  i_bx,
    input  wire logic signed [31:0]  i_by,
    input  wire logic signed [31:0]  i_bz,
    input  wire logic signed [31:0]  i_s,
    output logic                     o_valid,
    output vau_pkg::t_item           o_item,
    input  wire logic                i_pop
);
    import vau_pkg::*;

    t_item                         dec;
    logic                          q_empty;
    logic [$clog2(IN_DEPTH+1)-1:0] q_count;

    always_comb begin
        dec.ax = i_ax;
        dec.ay = i_ay;
        dec.az = i_az;
        dec.bx = i_bx;
        dec.by = i_by;
        dec.bz = i_bz;
        dec.s  = i_s;
        unique case (i_func)
            FUNC_ADD:   dec.op = OP_ADD;
            FUNC_SUB:   dec.op = OP_SUB;
            FUNC_NEG:   dec.op = OP_NEG;
            FUNC_SCALE: dec.op = OP_SCALE;
            FUNC_DIV:   dec.op = OP_DIV;
            FUNC_DOT:   dec.op = OP_DOT;
            FUNC_CROSS: dec.op = OP_CROSS;
            FUNC_LENSQ: dec.op = OP_LENSQ;
            FUNC_LEN:   dec.op = OP_LEN;
            FUNC_NORM:  dec.op = OP_NORM;
            default:    dec.op = OP_NONE;
        endcase
    end

    vau_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (IN_DEPTH)
    ) u_inq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (dec),
        .i_rd    (i_pop),
        .o_rdata (o_item),
        .o_full  (o_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign o_valid = !q_empty && (q_count != '0);
endmodule
`default_nettype wire

[src/vau_iter.sv]
// iterative square root and shift-subtract divider for divide, length and normalize
`default_nettype none
module vau_iter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire vau_pkg::t_op       i_op,
    input  wire logic signed [31:0] i_ax,
    input  wire logic signed [31:0] i_ay,
    input  wire logic signed [31:0] i_az,
    input  wire logic signed [31:0] i_s,
    input  wire logic [63:0]        i_sq,
    output logic                    o_busy,
    output logic                    o_done,
    output vau_pkg::t_res           o_res
);
    import vau_pkg::*;

    t_lu_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    t_op          r_op;
    logic         r_dneg;
    logic [2:0]   r_aneg;
    logic [63:0]  r_sqv;
    logic [33:0]  r_rem;
    logic [31:0]  r_root;
    logic [32:0]  r_den;
    logic [32:0]  r_dr [3];
    logic [47:0]  r_dq [3];
    t_res         r_res;

    logic [35:0]  rt_rem, rt_trial;
    logic         rt_ge;
    logic [32:0]  len;
    logic [33:0]  dv_t [3];
    logic         dv_ge [3];
    logic [32:0]  s_mag;
    logic [32:0]  a_mag [3];
    logic signed [31:0] a_in [3];
    logic signed [65:0] qv [3];
    t_clamp       qc [3];

    assign a_in[0] = i_ax;
    assign a_in[1] = i_ay;
    assign a_in[2] = i_az;

    always_comb begin
        s_mag = i_s[31] ? 33'(-33'(i_s)) : 33'(i_s);
        for (int i = 0; i < 3; i++) begin
            a_mag[i] = a_in[i][31] ? 33'(-33'(a_in[i])) : 33'(a_in[i]);
        end
        // one root digit per cycle
        rt_rem   = {r_rem, r_sqv[63:62]};
        rt_trial = {2'b00, r_root, 2'b01};
        rt_ge    = (rt_rem >= rt_trial);
        len      = {1'b0, r_root} + 33'(({2'b00, r_root} < r_rem));
        for (int i = 0; i < 3; i++) begin
            dv_t[i]  = {r_dr[i], r_dq[i][47]};
            dv_ge[i] = (dv_t[i] >= {1'b0, r_den});
            qv[i]    = (r_aneg[i] ^ r_dneg) ? -$signed({18'b0, r_dq[i]})
                                            : $signed({18'b0, r_dq[i]});
            qc[i]    = sat32(qv[i]);
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    if (i_op == OP_DIV) begin
                        n_state = (i_s == '0) ? ST_DONE : ST_DIV;
                    end else begin
                        n_state = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ROOT_STEPS-1)) begin
                    n_state = ST_RND;
                end
            end
            ST_RND: begin
                n_cnt = '0;
                if (r_op == OP_LEN || len == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS-1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:  n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_op   <= i_op;
                r_sqv  <= i_sq;
                r_rem  <= '0;
                r_root <= '0;
                r_den  <= s_mag;
                r_dneg <= i_s[31];
                r_res  <= '{rx: '0, ry: '0, rz: '0, so: '0,
                            err: (i_op == OP_DIV && i_s == '0), sat: 1'b0};
                for (int i = 0; i < 3; i++) begin
                    r_aneg[i] <= a_in[i][31];
                    r_dr[i]   <= '0;
                    r_dq[i]   <= {a_mag[i][31:0], 16'b0};
                end
            end
            ST_ROOT: begin
                r_sqv  <= {r_sqv[61:0], 2'b00};
                r_rem  <= rt_ge ? 34'(rt_rem - rt_trial) : rt_rem[33:0];
                r_root <= {r_root[30:0], rt_ge};
            end
            ST_RND: begin
                r_den  <= len;
                r_dneg <= 1'b0;
                if (r_op == OP_LEN) begin
                    if (len > 33'h0_7FFF_FFFF) begin
                        r_res.so  <= 32'sh7FFF_FFFF;
                        r_res.sat <= 1'b1;
                    end else begin
                        r_res.so  <= len[31:0];
                    end
                end else if (len == '0) begin
                    r_res.err <= 1'b1;
                end
            end
            ST_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_dr[i] <= dv_ge[i] ? 33'(dv_t[i] - {1'b0, r_den}) : dv_t[i][32:0];
                    r_dq[i] <= {r_dq[i][46:0], dv_ge[i]};
                end
            end
            ST_FIN: begin
                r_res.rx  <= qc[0].v;
                r_res.ry  <= qc[1].v;
                r_res.rz  <= qc[2].v;
                r_res.sat <= qc[0].sat | qc[1].sat | qc[2].sat;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);
    assign o_res  = r_res;
endmodule
`default_nettype wire

[src/vau_back.sv]
// back end: multiply and sum pipeline, long-operation unit and result queue
`default_nettype none
module vau_back #(
    parameter int OUT_DEPTH = vau_pkg::DEF_OUT_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire vau_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_empty,
    input  wire logic           i_pop,
    output vau_pkg::t_res       o_res
);
    import vau_pkg::*;

    localparam int RW = $clog2(OUT_DEPTH+4);

    // stage 1
    logic               r_v1;
    t_item              r_it1;
    logic signed [63:0] r_m [6];
    logic signed [32:0] r_e [3];
    // stage 2
    logic               r_v2;
    t_op                r_op2;
    logic signed [31:0] r_a2 [3];
    logic signed [31:0] r_s2;
    logic [63:0]        r_sq2;
    logic signed [65:0] r_w2 [4];

    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    logic signed [31:0] ma [6];
    logic signed [31:0] mb [6];
    logic signed [32:0] n_e [3];
    logic signed [65:0] m66 [6];
    logic signed [65:0] dsum;
    logic signed [65:0] n_w [4];
    t_clamp             pc [4];
    t_res               pres, wres;

    logic               issue, hold, lu_start, lu_busy, lu_done, pipe_wr;
    t_res               lu_res;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_cnt;
    logic               out_full;
    logic [RW-1:0]      reserved;

    assign va[0] = i_item.ax;
    assign va[1] = i_item.ay;
    assign va[2] = i_item.az;
    assign vb[0] = i_item.bx;
    assign vb[1] = i_item.by;
    assign vb[2] = i_item.bz;

    // results already owed to the output queue, so it can never overflow
    assign reserved = RW'(out_cnt) + RW'(r_v1) + RW'(r_v2) + RW'(lu_busy);
    assign hold     = lu_busy || (r_v1 && is_long(r_it1.op)) || (r_v2 && is_long(r_op2));
    assign issue    = i_valid && !hold && (reserved < RW'(OUT_DEPTH))
                      && (!is_long(i_item.op) || (!r_v1 && !r_v2));
    assign o_pop    = issue;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            ma[i] = '0;
            mb[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            n_e[i] = '0;
        end
        case (i_item.op) inside
            OP_ADD: for (int i = 0; i < 3; i++) n_e[i] = 33'(va[i]) + 33'(vb[i]);
            OP_SUB: for (int i = 0; i < 3; i++) n_e[i] = 33'(va[i]) - 33'(vb[i]);
            OP_NEG: for (int i = 0; i < 3; i++) n_e[i] = -33'(va[i]);
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    ma[i] = va[i];
                    mb[i] = i_item.s;
                end
            end
            OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    ma[i] = va[i];
                    mb[i] = vb[i];
                end
            end
            OP_LENSQ, OP_LEN, OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    ma[i] = va[i];
                    mb[i] = va[i];
                end
            end
            OP_CROSS: begin
                ma[0] = va[1]; mb[0] = vb[2];
                ma[1] = va[2]; mb[1] = vb[0];
                ma[2] = va[0]; mb[2] = vb[1];
                ma[3] = va[2]; mb[3] = vb[1];
                ma[4] = va[0]; mb[4] = vb[2];
                ma[5] = va[1]; mb[5] = vb[0];
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            m66[i] = 66'(r_m[i]);
        end
        dsum = m66[0] + m66[1] + m66[2];
        for (int i = 0; i < 4; i++) begin
            n_w[i] = '0;
        end
        case (r_it1.op) inside
            OP_ADD, OP_SUB, OP_NEG: begin
                for (int i = 0; i < 3; i++) n_w[i] = 66'(r_e[i]);
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) n_w[i] = (m66[i] + W_RND) >>> 16;
            end
            OP_DOT, OP_LENSQ: n_w[3] = (dsum + W_RND) >>> 16;
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) n_w[i] = (m66[i] - m66[i+3] + W_RND) >>> 16;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it1 <= i_item;
        for (int i = 0; i < 6; i++) begin
            r_m[i] <= ma[i] * mb[i];
        end
        for (int i = 0; i < 3; i++) begin
            r_e[i] <= n_e[i];
        end
        r_op2   <= r_it1.op;
        r_a2[0] <= r_it1.ax;
        r_a2[1] <= r_it1.ay;
        r_a2[2] <= r_it1.az;
        r_s2    <= r_it1.s;
        r_sq2   <= dsum[63:0];
        for (int i = 0; i < 4; i++) begin
            r_w2[i] <= n_w[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pc[i] = sat32(r_w2[i]);
        end
        pres.rx  = pc[0].v;
        pres.ry  = pc[1].v;
        pres.rz  = pc[2].v;
        pres.so  = pc[3].v;
        pres.err = 1'b0;
        pres.sat = pc[0].sat | pc[1].sat | pc[2].sat | pc[3].sat;
    end

    assign lu_start = r_v2 && is_long(r_op2);
    assign pipe_wr  = r_v2 && !is_long(r_op2);
    assign wres     = lu_done ? lu_res : pres;

    vau_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lu_start),
        .i_op    (r_op2),
        .i_ax    (r_a2[0]),
        .i_ay    (r_a2[1]),
        .i_az    (r_a2[2]),
        .i_s     (r_s2),
        .i_sq    (r_sq2),
        .o_busy  (lu_busy),
        .o_done  (lu_done),
        .o_res   (lu_res)
    );

    vau_queue #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (pipe_wr || lu_done),
        .i_wdata (wres),
        .i_rd    (i_pop),
        .o_rdata (o_res),
        .o_full  (out_full),
        .o_empty (o_empty),
        .o_count (out_cnt)
    );

    logic unused_full;
    assign unused_full = out_full;
endmodule
`default_nettype wire

[src/vector3_arithmetic_unit_core.sv]
// top level of the three-component Q16.16 vector arithmetic unit
`default_nettype none
// Add, subtract, negate, scale, dot, cross and squared length stream through a
// two-stage multiply and sum pipeline at one transaction per clock while no long
// operation holds the back end and the output queue has room. Divide, length and
// normalize go through one shared iterative unit in order: length takes a root,
// divide a quotient (three lanes in parallel) and normalize a root and then a
// quotient, and transactions behind them wait in the input queue. Division by
// zero and normalizing a zero vector give zeros with div_error set.
module vector3_arithmetic_unit_core #(
    parameter int IN_DEPTH  = vau_pkg::DEF_IN_DEPTH,
    parameter int OUT_DEPTH = vau_pkg::DEF_OUT_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [3:0]         i_func,
    input  wire logic signed [31:0] i_ax,
    input  wire logic signed [31:0] i_ay,
    input  wire logic signed [31:0] i_az,
    input  wire logic signed [31:0] i_bx,
    input  wire logic signed [31:0] i_by,
    input  wire logic signed [31:0] i_bz,
    input  wire logic signed [31:0] i_scalar_in,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      o_rx,
    output logic signed [31:0]      o_ry,
    output logic signed [31:0]      o_rz,
    output logic signed [31:0]      o_scalar_out,
    output logic                    o_div_error,
    output logic                    o_saturated
);
    import vau_pkg::*;

    logic  f_valid, f_pop;
    t_item f_item;
    t_res  res;

    vau_front #(.IN_DEPTH(IN_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_func  (i_func),
        .i_ax    (i_ax),
        .i_ay    (i_ay),
        .i_az    (i_az),
        .i_bx    (i_bx),
        .i_by    (i_by),
        .i_bz    (i_bz),
        .i_s     (i_scalar_in),
        .o_valid (f_valid),
        .o_item  (f_item),
        .i_pop   (f_pop)
    );

    vau_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_item  (f_item),
        .o_pop   (f_pop),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res)
    );

    assign o_rx         = res.rx;
    assign o_ry         = res.ry;
    assign o_rz         = res.rz;
    assign o_scalar_out = res.so;
    assign o_div_error  = res.err;
    assign o_saturated  = res.sat;

    // an error result is all zero and never clamped
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_div_error) |-> (o_rx == '0 && o_ry == '0 && o_rz == '0
                                     && o_scalar_out == '0 && !o_saturated))
        else $error("error result carries data");

    // scalar and vector results never share one transaction
    a_scalar_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_scalar_out != '0) |-> (o_rx == '0 && o_ry == '0 && o_rz == '0))
        else $error("scalar result with vector data");

    // the back end never pops the input queue while it holds nothing
    a_no_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_pop |-> f_valid)
        else $error("issue from empty input queue");
endmodule
`default_nettype wire

[verif/vector3_arithmetic_unit_core_test.sv]
// self-checking testbench for the three-component Q16.16 vector arithmetic unit
`default_nettype none
module vector3_arithmetic_unit_core_test;
    import vau_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct {
        logic [3:0]         func;
        logic signed [31:0] ax, ay, az, bx, by, bz, s;
    } vec_op_t;

    typedef struct packed {
        logic signed [31:0] rx, ry, rz, so;
        logic               err, sat;
    } vec_res_t;

    // exact Q16.16 vector arithmetic, mirrors the block's numeric contract
    class vec_result_board;
        vec_res_t pending[$];
        int       n_bad;

        function logic signed [127:0] asr16(input logic signed [127:0] v);
            return v >>> 16;
        endfunction

        function logic signed [31:0] clamp(input logic signed [127:0] v, inout logic sat);
            if (v > 128'sd2147483647) begin
                sat = 1'b1;
                return 32'sh7FFF_FFFF;
            end
            if (v < -128'sd2147483648) begin
                sat = 1'b1;
                return 32'sh8000_0000;
            end
            return v[31:0];
        endfunction

        // truncating quotient, magnitude capped like the block's divider
        function logic signed [127:0] qdiv(input logic signed [127:0] num,
                                           input logic signed [127:0] den);
            logic signed [127:0] n, un, ud, q;
            n  = num * 65536;
            un = (n < 0) ? -n : n;
            ud = (den < 0) ? -den : den;
            q  = un / ud;
            if (q > 128'sh FFFF_FFFF_FFFE) q = 128'sh FFFF_FFFF_FFFE;
            return ((n < 0) != (den < 0)) ? -q : q;
        endfunction

        function logic [63:0] root_near(input logic [63:0] sq);
            logic [65:0] op, res, one;
            op  = sq;
            res = 0;
            one = 66'd1 << 62;
            while (one > op) one = one >> 2;
            while (one != 0) begin
                if (op >= res + one) begin
                    op  = op - (res + one);
                    res = (res >> 1) + one;
                end else begin
                    res = res >> 1;
                end
                one = one >> 2;
            end
            if (op > res) res = res + 1;
            return res[63:0];
        endfunction

        function vec_res_t compute(input vec_op_t t);
            vec_res_t            r;
            logic signed [127:0] a[3], b[3], s, sq, len, v;
            logic                sat;
            r   = '{0, 0, 0, 0, 1'b0, 1'b0};
            sat = 1'b0;
            a[0] = t.ax; a[1] = t.ay; a[2] = t.az;
            b[0] = t.bx; b[1] = t.by; b[2] = t.bz;
            s = t.s;
            case (t.func)
                FUNC_ADD: begin
                    r.rx = clamp(a[0] + b[0], sat);
                    r.ry = clamp(a[1] + b[1], sat);
                    r.rz = clamp(a[2] + b[2], sat);
                end
                FUNC_SUB: begin
                    r.rx = clamp(a[0] - b[0], sat);
                    r.ry = clamp(a[1] - b[1], sat);
                    r.rz = clamp(a[2] - b[2], sat);
                end
                FUNC_NEG: begin
                    r.rx = clamp(-a[0], sat);
                    r.ry = clamp(-a[1], sat);
                    r.rz = clamp(-a[2], sat);
                end
                FUNC_SCALE: begin
                    r.rx = clamp(asr16(a[0] * s + 32768), sat);
                    r.ry = clamp(asr16(a[1] * s + 32768), sat);
                    r.rz = clamp(asr16(a[2] * s + 32768), sat);
                end
                FUNC_DIV: begin
                    if (s == 0) r.err = 1'b1;
                    else begin
                        r.rx = clamp(qdiv(a[0], s), sat);
                        r.ry = clamp(qdiv(a[1], s), sat);
                        r.rz = clamp(qdiv(a[2], s), sat);
                    end
                end
                FUNC_DOT:
                    r.so = clamp(asr16(a[0] * b[0] + a[1] * b[1] + a[2] * b[2] + 32768), sat);
                FUNC_CROSS: begin
                    r.rx = clamp(asr16(a[1] * b[2] - a[2] * b[1] + 32768), sat);
                    r.ry = clamp(asr16(a[2] * b[0] - a[0] * b[2] + 32768), sat);
                    r.rz = clamp(asr16(a[0] * b[1] - a[1] * b[0] + 32768), sat);
                end
                FUNC_LENSQ, FUNC_LEN, FUNC_NORM: begin
                    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                    if (t.func == FUNC_LENSQ) begin
                        r.so = clamp((sq + 32768) >>> 16, sat);
                    end else begin
                        len = root_near(sq[63:0]);
                        if (t.func == FUNC_LEN) r.so = clamp(len, sat);
                        else if (len == 0) r.err = 1'b1;
                        else begin
                            r.rx = clamp(qdiv(a[0], len), sat);
                            r.ry = clamp(qdiv(a[1], len), sat);
                            r.rz = clamp(qdiv(a[2], len), sat);
                        end
                    end
                end
                default: ;
            endcase
            r.sat = sat;
            return r;
        endfunction

        function void note_op(input vec_op_t t);
            pending.push_back(compute(t));
        endfunction

        function void check_result(input vec_res_t got);
            vec_res_t want;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result transaction rx=%h", got.rx);
                return;
            end
            want = pending.pop_front();
            if (got != want) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch: want %h %h %h so=%h e=%b s=%b got %h %h %h so=%h e=%b s=%b",
                             want.rx, want.ry, want.rz, want.so, want.err, want.sat,
                             got.rx, got.ry, got.rz, got.so, got.err, got.sat);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic [3:0]         i_func = '0;
    logic signed [31:0] i_ax = '0, i_ay = '0, i_az = '0;
    logic signed [31:0] i_bx = '0, i_by = '0, i_bz = '0, i_scalar_in = '0;
    logic               full, empty, o_div_error, o_saturated;
    logic signed [31:0] o_rx, o_ry, o_rz, o_scalar_out;

    vector3_arithmetic_unit_core dut (.*);

    always #2 i_clk = ~i_clk;

    vec_result_board board = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  idle_cycles = 0;
    bit  pop_on = 1'b0;

    // result side: accept on pop & !empty, then pick next pop value
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            board.check_result('{o_rx, o_ry, o_rz, o_scalar_out, o_div_error, o_saturated});
        end
        if (i_rst_n && ((push && !full) || (pop && !empty))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        pop <= pop_on && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL vector3_arithmetic_unit_core");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_val();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 0;
            3: return $signed($urandom_range(32'h3_0000)) - 32'sh1_8000;
            4: return $signed($urandom) >>> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input vec_op_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_func <= t.func;
        i_ax <= t.ax; i_ay <= t.ay; i_az <= t.az;
        i_bx <= t.bx; i_by <= t.by; i_bz <= t.bz;
        i_scalar_in <= t.s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_op(t);
    endtask

    task automatic random_ops(input int n);
        vec_op_t t;
        repeat (n) begin
            t.func = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                                : 4'($urandom_range(9));
            t.ax = pick_val(); t.ay = pick_val(); t.az = pick_val();
            t.bx = pick_val(); t.by = pick_val(); t.bz = pick_val();
            t.s  = ($urandom_range(9) == 0) ? 0 : pick_val();
            if (t.func == FUNC_NORM && $urandom_range(7) == 0) begin
                t.ax = 0; t.ay = 0; t.az = 0;
            end
            send_op(t);
        end
    endtask

    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        pop_on = 1'b1;
        @(posedge i_clk);
        // directed: every operation, extremes, zero divisor, zero vector, length overflow
        for (int f = 0; f < 10; f++)
            send_op('{4'(f), MAXV, MINV, ONE, MINV, MAXV, -ONE, 32'sh0002_8000});
        send_op('{FUNC_DIV, ONE, MAXV, MINV, 0, 0, 0, 0});
        send_op('{FUNC_DIV, MINV, MAXV, ONE, 0, 0, 0, 32'sh0000_0001});
        send_op('{FUNC_NORM, 0, 0, 0, ONE, ONE, ONE, ONE});
        send_op('{FUNC_NORM, 0, 0, 32'sh0000_0001, 0, 0, 0, 0});
        send_op('{FUNC_NEG, MINV, MINV, MINV, 0, 0, 0, 0});
        send_op('{FUNC_LEN, MINV, MINV, MINV, 0, 0, 0, 0});
        send_op('{FUNC_LENSQ, MINV, MAXV, MINV, 0, 0, 0, 0});
        send_op('{FUNC_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0});
        send_op('{FUNC_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0});
        send_op('{FUNC_SCALE, MINV, MAXV, ONE, 0, 0, 0, MINV});
        send_op('{4'd15, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        send_op('{4'd10, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
        random_ops(400);
        send_idle_pct = 71; recv_stall_pct = 0;
        random_ops(400);
        send_idle_pct = 0; recv_stall_pct = 71;
        random_ops(400);
        send_idle_pct = 26; recv_stall_pct = 26;
        random_ops(400);
        push <= 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.n_bad == 0) $display("PASS vector3_arithmetic_unit_core");
        else $display("FAIL vector3_arithmetic_unit_core");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
src/vau_pkg.sv
src/vau_queue.sv
src/vau_front.sv
src/vau_iter.sv
src/vau_back.sv
src/vector3_arithmetic_unit_core.sv
verif/vector3_arithmetic_unit_core_test.sv
